// File: sv/bda_pkg.sv
// Buddy allocator package: geometry constants, codes and controller/datapath interface types.
package bda_pkg;

    localparam int POOL_BYTES      = 1024;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int UNITS           = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int UNIT_W          = $clog2(UNITS);
    localparam int TOP_ORDER       = $clog2(UNITS);
    localparam int ORD_W           = $clog2(TOP_ORDER + 1);
    localparam int MAP_BITS        = 2 * UNITS - 1;
    localparam int MAP_W           = $clog2(MAP_BITS);
    localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
    localparam int ADDR_W          = 10;
    localparam int SIZE_W          = 11;
    localparam int TAG_W           = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_bda_status;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_SEARCH,
        DP_SPLIT,
        DP_TAKE,
        DP_MERGE
    } t_bda_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_SPLIT,
        S_FREE_CHK,
        S_MERGE,
        S_FINISH
    } t_bda_state;

    typedef struct packed {
        t_bda_op     op;
        logic        res_load;
        t_bda_status res_code;
    } t_bda_cmd;

    typedef struct packed {
        logic bad_size;
        logic found;
        logic at_target;
        logic at_top;
        logic split_last;
        logic free_bad;
        logic buddy_free;
        logic out_free;
    } t_bda_stat;

endpackage

// File: sv/bda_dp.sv
// Buddy allocator datapath: free bitmaps, block tag memory, walk registers, result register.
module bda_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bda_pkg::t_bda_cmd            i_cmd,
    output bda_pkg::t_bda_stat           o_stat,
    input  logic                         i_operation,
    input  logic [bda_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [bda_pkg::ADDR_W-1:0]   i_block_address,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [bda_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [bda_pkg::SIZE_W-1:0]   o_granted_size
);

    localparam int UW = bda_pkg::UNIT_W;
    localparam int OW = bda_pkg::ORD_W;
    localparam int MW = bda_pkg::MAP_W;

    // first bit of order k in the flat map
    function automatic logic [MW-1:0] order_base(input logic [OW-1:0] k);
        logic [MW-1:0] b;
        b = '0;
        for (int j = 0; j < bda_pkg::TOP_ORDER; j++) begin
            if (OW'(j) < k) b = b + MW'(bda_pkg::UNITS >> j);
        end
        return b;
    endfunction

    function automatic logic [MW-1:0] map_index(input logic [OW-1:0] k,
                                                input logic [UW-1:0] unit);
        return order_base(k) + MW'(unit >> k);
    endfunction

    // registers
    logic [bda_pkg::MAP_BITS-1:0] r_free_map;
    logic [bda_pkg::TAG_W-1:0]    r_tag_mem [bda_pkg::UNITS];
    logic [bda_pkg::UNITS-1:0]    r_tag_vld;
    logic [bda_pkg::TAG_W-1:0]    r_tag_rd;
    logic                         r_tag_rd_vld;
    logic                         r_is_free;
    logic                         r_bad_size;
    logic                         r_bad_align;
    logic [bda_pkg::ADDR_W-1:0]   r_addr;
    logic [OW-1:0]                r_k;
    logic [OW-1:0]                r_order;
    logic [UW-1:0]                r_unit;
    logic                         r_out_valid;
    bda_pkg::t_bda_status         r_out_status;
    logic [bda_pkg::ADDR_W-1:0]   r_out_addr;
    logic [bda_pkg::SIZE_W-1:0]   r_out_size;

    logic [OW-1:0]                n_order;
    logic [UW-1:0]                n_unit;
    logic                         n_map_we;
    logic                         n_map_val;
    logic [MW-1:0]                n_map_idx;
    logic                         n_tag_we;
    logic                         n_tag_clr;
    logic [UW-1:0]                n_tag_addr;

    // request decode
    logic [bda_pkg::SIZE_W-1:0]   w_size_m1;
    logic [UW:0]                  w_units_m1;
    logic [OW-1:0]                w_k_calc;
    logic                         w_bad_size_calc;

    // order row search
    logic [bda_pkg::UNITS-1:0]    w_row;
    logic [UW-1:0]                w_idx;
    logic                         w_found;
    logic [UW-1:0]                w_found_unit;
    logic [OW-1:0]                w_order_dn;
    logic [UW-1:0]                w_bit;
    logic [UW-1:0]                w_bit_dn;
    logic [UW-1:0]                w_buddy;
    logic                         w_buddy_free;
    logic                         w_at_top;
    logic                         w_out_free;

    always_comb begin
        w_size_m1       = i_request_size - bda_pkg::SIZE_W'(1);
        w_units_m1      = (UW + 1)'(w_size_m1 >> bda_pkg::MIN_SHIFT);
        w_k_calc        = '0;
        for (int b = 0; b <= UW; b++) begin
            if (w_units_m1[b]) w_k_calc = OW'(b + 1);
        end
        w_bad_size_calc = (i_request_size == '0) ||
                          (i_request_size > bda_pkg::SIZE_W'(bda_pkg::POOL_BYTES));
    end

    always_comb begin
        w_row = '0;
        for (int b = 0; b < bda_pkg::UNITS; b++) begin
            if ((b >> r_order) == 0 || b < (bda_pkg::UNITS >> r_order)) begin
                if (b < (bda_pkg::UNITS >> r_order))
                    w_row[b] = r_free_map[MW'(order_base(r_order) + MW'(b))];
            end
        end
        w_idx   = '0;
        w_found = 1'b0;
        for (int b = bda_pkg::UNITS - 1; b >= 0; b--) begin
            if (w_row[b]) begin
                w_idx   = UW'(b);
                w_found = 1'b1;
            end
        end
        w_found_unit = UW'(w_idx << r_order);
        w_order_dn   = r_order - OW'(1);
        w_bit        = UW'(1) << r_order;
        w_bit_dn     = UW'(1) << w_order_dn;
        w_buddy      = r_unit ^ w_bit;
        w_buddy_free = r_free_map[map_index(r_order, w_buddy)];
        w_at_top     = (r_order == OW'(bda_pkg::TOP_ORDER));
        w_out_free   = !r_out_valid || i_ready;
    end

    always_comb begin
        o_stat.bad_size   = r_bad_size;
        o_stat.found      = w_found;
        o_stat.at_target  = (r_order == r_k);
        o_stat.at_top     = w_at_top;
        o_stat.split_last = (w_order_dn == r_k);
        o_stat.free_bad   = r_bad_align || !r_tag_rd_vld || (r_tag_rd == '0) ||
                            (r_tag_rd > bda_pkg::TAG_W'(bda_pkg::TOP_ORDER + 1));
        o_stat.buddy_free = w_buddy_free;
        o_stat.out_free   = w_out_free;
    end

    // step decode
    always_comb begin
        n_order    = r_order;
        n_unit     = r_unit;
        n_map_we   = 1'b0;
        n_map_val  = 1'b0;
        n_map_idx  = '0;
        n_tag_we   = 1'b0;
        n_tag_clr  = 1'b0;
        n_tag_addr = r_unit;
        unique case (i_cmd.op)
            bda_pkg::DP_NOP: begin
            end
            bda_pkg::DP_LOAD: begin
                n_order = w_k_calc;
            end
            bda_pkg::DP_SEARCH: begin
                if (w_found) begin
                    n_map_we   = 1'b1;
                    n_map_idx  = map_index(r_order, w_found_unit);
                    n_unit     = w_found_unit;
                    n_tag_addr = w_found_unit;
                    n_tag_we   = (r_order == r_k);
                end else begin
                    n_order = r_order + OW'(1);
                end
            end
            bda_pkg::DP_SPLIT: begin
                n_map_we   = 1'b1;
                n_map_val  = 1'b1;
                n_map_idx  = map_index(w_order_dn, r_unit | w_bit_dn);
                n_order    = w_order_dn;
                n_tag_we   = (w_order_dn == r_k);
            end
            bda_pkg::DP_TAKE: begin
                n_order    = OW'(r_tag_rd - bda_pkg::TAG_W'(1));
                n_unit     = r_addr[bda_pkg::ADDR_W-1 -: UW];
                n_tag_addr = r_addr[bda_pkg::ADDR_W-1 -: UW];
                n_tag_clr  = 1'b1;
            end
            bda_pkg::DP_MERGE: begin
                n_map_we = 1'b1;
                if (!w_at_top && w_buddy_free) begin
                    n_map_idx = map_index(r_order, w_buddy);
                    n_unit    = r_unit & ~w_bit;
                    n_order   = r_order + OW'(1);
                end else begin
                    n_map_val = 1'b1;
                    n_map_idx = map_index(r_order, r_unit);
                end
            end
            default: begin
            end
        endcase
    end

    // control state and bitmaps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= bda_pkg::MAP_BITS'(1) << (bda_pkg::MAP_BITS - 1);
            r_tag_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_map_we) r_free_map[n_map_idx] <= n_map_val;
            if (n_tag_we) r_tag_vld[n_tag_addr] <= 1'b1;
            if (n_tag_clr) r_tag_vld[n_tag_addr] <= 1'b0;
            if (i_cmd.res_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // tag memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (n_tag_we) r_tag_mem[n_tag_addr] <= bda_pkg::TAG_W'(r_k) + bda_pkg::TAG_W'(1);
        if (i_cmd.op == bda_pkg::DP_LOAD) begin
            r_tag_rd     <= r_tag_mem[i_block_address[bda_pkg::ADDR_W-1 -: UW]];
            r_tag_rd_vld <= r_tag_vld[i_block_address[bda_pkg::ADDR_W-1 -: UW]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_order <= n_order;
        r_unit  <= n_unit;
        if (i_cmd.op == bda_pkg::DP_LOAD) begin
            r_is_free   <= i_operation;
            r_addr      <= i_block_address;
            r_k         <= w_k_calc;
            r_bad_size  <= w_bad_size_calc;
            r_bad_align <= (i_block_address[bda_pkg::MIN_SHIFT-1:0] != '0);
        end else if (i_cmd.op == bda_pkg::DP_TAKE) begin
            r_k <= OW'(r_tag_rd - bda_pkg::TAG_W'(1));
        end
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_code;
            if (i_cmd.res_code == bda_pkg::ST_OK) begin
                r_out_addr <= r_is_free ? r_addr :
                              bda_pkg::ADDR_W'(r_unit) << bda_pkg::MIN_SHIFT;
                r_out_size <= bda_pkg::SIZE_W'(bda_pkg::MIN_BLOCK_BYTES) << r_k;
            end else begin
                r_out_addr <= '0;
                r_out_size <= '0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_addr;
    assign o_granted_size    = r_out_size;

endmodule

// File: sv/bda_ctrl.sv
// Buddy allocator controller: sequences search, split, free check and merge steps.
module bda_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_operation,
    output logic                o_ready,
    input  bda_pkg::t_bda_stat  i_stat,
    output bda_pkg::t_bda_cmd   o_cmd
);

    bda_pkg::t_bda_state  r_state, n_state;
    bda_pkg::t_bda_status r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::S_IDLE;
            r_res   <= bda_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        o_ready        = 1'b0;
        o_cmd.op       = bda_pkg::DP_NOP;
        o_cmd.res_load = 1'b0;
        o_cmd.res_code = r_res;
        unique case (r_state)
            bda_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = bda_pkg::DP_LOAD;
                    n_state  = i_operation ? bda_pkg::S_FREE_CHK : bda_pkg::S_ALLOC;
                end
            end
            bda_pkg::S_ALLOC: begin
                if (i_stat.bad_size) begin
                    n_res   = bda_pkg::ST_BAD_SIZE;
                    n_state = bda_pkg::S_FINISH;
                end else if (i_stat.found) begin
                    o_cmd.op = bda_pkg::DP_SEARCH;
                    if (i_stat.at_target) begin
                        n_res   = bda_pkg::ST_OK;
                        n_state = bda_pkg::S_FINISH;
                    end else begin
                        n_state = bda_pkg::S_SPLIT;
                    end
                end else if (i_stat.at_top) begin
                    n_res   = bda_pkg::ST_NO_MEM;
                    n_state = bda_pkg::S_FINISH;
                end else begin
                    o_cmd.op = bda_pkg::DP_SEARCH;
                end
            end
            bda_pkg::S_SPLIT: begin
                o_cmd.op = bda_pkg::DP_SPLIT;
                if (i_stat.split_last) begin
                    n_res   = bda_pkg::ST_OK;
                    n_state = bda_pkg::S_FINISH;
                end
            end
            bda_pkg::S_FREE_CHK: begin
                if (i_stat.free_bad) begin
                    n_res   = bda_pkg::ST_BAD_FREE;
                    n_state = bda_pkg::S_FINISH;
                end else begin
                    o_cmd.op = bda_pkg::DP_TAKE;
                    n_state  = bda_pkg::S_MERGE;
                end
            end
            bda_pkg::S_MERGE: begin
                o_cmd.op = bda_pkg::DP_MERGE;
                if (i_stat.at_top || !i_stat.buddy_free) begin
                    n_res   = bda_pkg::ST_OK;
                    n_state = bda_pkg::S_FINISH;
                end
            end
            bda_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = bda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bda_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/buddy_allocator_unit.sv
// Buddy allocator top level: controller and datapath joined by command and status.
//
//  channel   signals                                          direction
//  request   i_valid/o_ready, i_operation, i_request_size,    in
//            i_block_address
//  result    o_valid/i_ready, o_status, o_granted_address,    out
//            o_granted_size
//
// One request at a time. Allocate: accept, search (one order per cycle, upward
// from the requested order), splits down to the requested order, finish. Free:
// accept, tag check, merges (one order per cycle, while the buddy is free),
// finish; a free rejected at the tag check goes from there straight to finish.
// The search walks over the orders, one bitmap row per cycle.
// Synchronous active-low reset leaves only the whole-pool block free and all
// tags clear at once; no clearing sweep. A stalled result waits in the output
// register; the finish step holds until that register is free.
module buddy_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_operation,
    input  logic [bda_pkg::SIZE_W-1:0]  i_request_size,
    input  logic [bda_pkg::ADDR_W-1:0]  i_block_address,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [bda_pkg::ADDR_W-1:0]  o_granted_address,
    output logic [bda_pkg::SIZE_W-1:0]  o_granted_size
);

    // command from controller, status back from datapath
    bda_pkg::t_bda_cmd  w_cmd;
    bda_pkg::t_bda_stat w_stat;

    bda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath holds the per-order free bitmaps, the per-unit tag memory and
    // the result register that parts the output transfer from the walk
    bda_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_operation       (i_operation),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_granted_size    (o_granted_size)
    );

endmodule
